@@ hdl/swhsr_pkg.sv @@
// Package for the single-wire humidity sensor reader.
// Holds the read phases, status codes, register indexes and frame constants.
// No dependencies.
package swhsr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_LOW       = 3'd1,
        PH_HIGH      = 3'd2,
        PH_RESP_LOW  = 3'd3,
        PH_RESP_HIGH = 3'd4,
        PH_DATA_LOW  = 3'd5,
        PH_BIT_RISE  = 3'd6,
        PH_BIT_HIGH  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TIMEOUT  = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } status_t;

    localparam logic [7:0] CFG_START_LOW    = 8'd0;
    localparam logic [7:0] CFG_RELEASE_HIGH = 8'd1;
    localparam logic [7:0] CFG_RESPONSE     = 8'd2;
    localparam logic [7:0] CFG_BIT_TIMEOUT  = 8'd3;
    localparam logic [7:0] CFG_THRESHOLD    = 8'd4;

    localparam logic [15:0] START_LOW_RESET    = 16'd18000;
    localparam logic [7:0]  RELEASE_HIGH_RESET = 8'd20;
    localparam logic [7:0]  RESPONSE_RESET     = 8'd100;
    localparam logic [7:0]  BIT_TIMEOUT_RESET  = 8'd120;
    localparam logic [7:0]  THRESHOLD_RESET    = 8'd50;

    localparam int unsigned FRAME_WIDTH = 40;
    localparam logic [5:0]  FRAME_BIT_COUNT = 6'd40;

    // Exact divide by ten for 16-bit values: (x * 52429) >> 19.
    localparam logic [16:0] DIV10_MUL = 17'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic        drive_enable;
        logic        drive_level;
        logic        busy;
        logic        done;
        status_t     status;
        logic        ok;
        logic [15:0] hum_raw;
        logic        temp_sign;
        logic [14:0] temp_mag;
    } stage_t;

endpackage

@@ hdl/single_wire_humidity_sensor_reader_top.sv @@
// Single-wire humidity and temperature sensor reader, top level.
// Depends on swhsr_pkg for phases, status codes and register indexes.
//
// Usage: each input transfer carries cmd and line_level. A start command
// (cmd = 1) begins a read when the block is idle; a tick (cmd = 0) advances
// the read by one microsecond using the sampled line level. Every input
// transfer yields exactly one output transfer holding the line drive for
// the coming microsecond, the busy flag and, on the transfer that ends a
// read, done_res with status, humidity_pct and temperature_c.
// The state update and checksum feed the middle stage register; the divide
// by ten (one reciprocal multiply) feeds the output register. One item is
// accepted every cycle while in_ready is high. When the receiver stalls,
// the output register holds its transfer and the middle stage still takes
// one more item; in_ready drops only when both stages are full.
// Configuration writes are always ready and must occur only while the block
// is idle.
// Reset sets the control, valid and config registers to reset values, but
// not the stage data registers; the block is ready once reset is released.
module single_wire_humidity_sensor_reader_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        line_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drive_enable,
    output logic        drive_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [12:0] humidity_pct,
    output logic signed [12:0] temperature_c
);
    import swhsr_pkg::*;

    logic [15:0] start_low_reg;
    logic [7:0]  release_high_reg;
    logic [7:0]  response_reg;
    logic [7:0]  bit_timeout_reg;
    logic [7:0]  threshold_reg;

    phase_t                   phase_reg, phase_next;
    logic [15:0]              cnt_reg, cnt_next;
    logic [5:0]               bit_idx_reg, bit_idx_next;
    logic [FRAME_WIDTH-1:0]   frame_reg, frame_next;

    logic        s1_valid_reg;
    stage_t      s1_reg, s1_next;
    logic        out_valid_reg;

    logic        out_load;
    logic        in_accept;

    logic [15:0]            cnt_inc;
    logic [5:0]             idx_inc;
    logic                   bit_value;
    logic [FRAME_WIDTH-1:0] frame_shift;
    logic [7:0]             sum8;

    logic [32:0] hum_prod;
    logic [32:0] temp_prod;
    logic [12:0] hum_q;
    logic [12:0] temp_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg    <= START_LOW_RESET;
            release_high_reg <= RELEASE_HIGH_RESET;
            response_reg     <= RESPONSE_RESET;
            bit_timeout_reg  <= BIT_TIMEOUT_RESET;
            threshold_reg    <= THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_LOW:    start_low_reg    <= cfg_data;
                CFG_RELEASE_HIGH: release_high_reg <= cfg_data[7:0];
                CFG_RESPONSE:     response_reg     <= cfg_data[7:0];
                CFG_BIT_TIMEOUT:  bit_timeout_reg  <= cfg_data[7:0];
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign out_load  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;

    assign cnt_inc     = cnt_reg + 16'd1;
    assign idx_inc     = bit_idx_reg + 6'd1;
    assign bit_value   = (cnt_reg > {8'd0, threshold_reg});
    assign frame_shift = {frame_reg[FRAME_WIDTH-2:0], bit_value};
    assign sum8        = frame_shift[39:32] + frame_shift[31:24]
                       + frame_shift[23:16] + frame_shift[15:8];

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        bit_idx_next = bit_idx_reg;
        frame_next   = frame_reg;
        s1_next      = '0;
        s1_next.status = STATUS_OK;

        if (cmd)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next   = PH_LOW;
                cnt_next     = '0;
                bit_idx_next = '0;
                frame_next   = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_LOW:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= start_low_reg)
                    begin
                        phase_next = PH_HIGH;
                        cnt_next   = '0;
                    end
                end
                PH_HIGH:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= {8'd0, release_high_reg})
                    begin
                        phase_next = PH_RESP_LOW;
                        cnt_next   = '0;
                    end
                end
                PH_RESP_LOW:
                begin
                    cnt_next = cnt_inc;
                    if (!line_level || cnt_inc >= {8'd0, response_reg})
                    begin
                        phase_next = PH_RESP_HIGH;
                        cnt_next   = '0;
                    end
                end
                PH_RESP_HIGH:
                begin
                    cnt_next = cnt_inc;
                    if (line_level || cnt_inc >= {8'd0, response_reg})
                    begin
                        phase_next = PH_DATA_LOW;
                        cnt_next   = '0;
                    end
                end
                PH_DATA_LOW:
                begin
                    cnt_next = cnt_inc;
                    if (!line_level || cnt_inc >= {8'd0, response_reg})
                    begin
                        phase_next = PH_BIT_RISE;
                        cnt_next   = '0;
                    end
                end
                PH_BIT_RISE:
                begin
                    if (line_level)
                    begin
                        phase_next = PH_BIT_HIGH;
                        cnt_next   = 16'd1;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc >= {8'd0, response_reg})
                        begin
                            phase_next = PH_BIT_HIGH;
                            cnt_next   = '0;
                        end
                    end
                end
                PH_BIT_HIGH:
                begin
                    if (line_level)
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc > {8'd0, bit_timeout_reg})
                        begin
                            s1_next.done   = 1'b1;
                            s1_next.status = STATUS_TIMEOUT;
                            phase_next     = PH_IDLE;
                            cnt_next       = '0;
                        end
                    end
                    else
                    begin
                        frame_next   = frame_shift;
                        bit_idx_next = idx_inc;
                        cnt_next     = '0;
                        if (idx_inc >= FRAME_BIT_COUNT)
                        begin
                            s1_next.done = 1'b1;
                            phase_next   = PH_IDLE;
                            if (sum8 != frame_shift[7:0])
                            begin
                                s1_next.status = STATUS_CHECKSUM;
                            end
                            else
                            begin
                                s1_next.ok = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_BIT_RISE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                end
            endcase
        end

        s1_next.hum_raw      = frame_shift[39:24];
        s1_next.temp_sign    = frame_shift[23];
        s1_next.temp_mag     = frame_shift[22:8];
        s1_next.drive_enable = (phase_next == PH_LOW) || (phase_next == PH_HIGH);
        s1_next.drive_level  = (phase_next == PH_HIGH);
        s1_next.busy         = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            bit_idx_reg <= '0;
            frame_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            bit_idx_reg <= bit_idx_next;
            frame_reg   <= frame_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign hum_prod  = {17'd0, s1_reg.hum_raw} * {16'd0, DIV10_MUL};
    assign temp_prod = {18'd0, s1_reg.temp_mag} * {16'd0, DIV10_MUL};
    assign hum_q     = hum_prod[DIV10_SHIFT+12:DIV10_SHIFT];
    assign temp_q    = temp_prod[DIV10_SHIFT+12:DIV10_SHIFT];

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            drive_enable <= s1_reg.drive_enable;
            drive_level  <= s1_reg.drive_level;
            busy_res     <= s1_reg.busy;
            done_res     <= s1_reg.done;
            status       <= s1_reg.status;
            if (s1_reg.ok)
            begin
                humidity_pct  <= hum_q;
                temperature_c <= s1_reg.temp_sign ? -$signed(temp_q) : $signed(temp_q);
            end
            else
            begin
                humidity_pct  <= '0;
                temperature_c <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/swhsr_checker.sv @@
// Port-level checker for the single-wire humidity sensor reader.
// Depends on swhsr_pkg; bound to single_wire_humidity_sensor_reader_top below.
module swhsr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        drive_enable,
    input logic        drive_level,
    input logic        busy_res,
    input logic        done_res,
    input logic [1:0]  status,
    input logic [12:0] humidity_pct,
    input logic [12:0] temperature_c
);
    import swhsr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(done_res))
        else $error("output transfer changed while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !drive_enable)
        else $error("finished read still reports busy");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> done_res)
        else $error("status reported without done");

    a_level_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_level |-> drive_enable && busy_res)
        else $error("line level driven while released");

    a_values_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!done_res || status != STATUS_OK)
        |-> humidity_pct == '0 && temperature_c == '0)
        else $error("measurement shown without a good read");

endmodule

bind single_wire_humidity_sensor_reader_top swhsr_checker u_swhsr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_enable  (drive_enable),
    .drive_level   (drive_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .status        (status),
    .humidity_pct  (humidity_pct),
    .temperature_c (temperature_c)
);

@@ verif/tb.sv @@
// Self-checking testbench for single_wire_humidity_sensor_reader_top.
// It plays a sensor on the data line, predicts every output transfer and checks it.
// Depends on swhsr_pkg and the reader RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swhsr_pkg::*;

    localparam int TOTAL_ITEMS = 1050;
    localparam int HOLD_AFTER = 800;
    localparam int HOLD_CYCLES = 400;
    localparam logic [7:0] CFG_NO_SUCH_REG = CFG_THRESHOLD + 8'd1;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_LONG_PULSE,
        FLAW_SLOW_RISE,
        FLAW_SLOW_RESPONSE,
        FLAW_CUT_SHORT
    } flaw_t;

    typedef struct packed {
        logic        drive_enable;
        logic        drive_level;
        logic        busy;
        logic        done;
        logic [1:0]  status;
        logic [12:0] humidity;
        logic [12:0] temperature;
    } report_t;

    class read_scoreboard;
        logic [15:0] start_low;
        logic [7:0]  release_high;
        logic [7:0]  response_wait;
        logic [7:0]  bit_timeout;
        logic [7:0]  one_threshold;
        phase_t      phase;
        logic [15:0] tick_count;
        logic [5:0]  bit_count;
        logic [39:0] frame;
        report_t     expected_reports[$];
        int          mismatches;
        int          checked;
        int          live_items;
        int          reads_ok;
        int          reads_timeout;
        int          reads_bad_sum;

        function new();
            start_low = START_LOW_RESET;
            release_high = RELEASE_HIGH_RESET;
            response_wait = RESPONSE_RESET;
            bit_timeout = BIT_TIMEOUT_RESET;
            one_threshold = THRESHOLD_RESET;
            phase = PH_IDLE;
            tick_count = '0;
            bit_count = '0;
            frame = '0;
        endfunction

        function bit reader_busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void set_reg(logic [7:0] idx, logic [15:0] data);
            case (idx)
                CFG_START_LOW:    start_low = data;
                CFG_RELEASE_HIGH: release_high = data[7:0];
                CFG_RESPONSE:     response_wait = data[7:0];
                CFG_BIT_TIMEOUT:  bit_timeout = data[7:0];
                CFG_THRESHOLD:    one_threshold = data[7:0];
                default:          ;
            endcase
        endfunction

        function void wait_for_level(logic lvl, logic want, phase_t next);
            if (lvl == want) begin
                phase = next;
                tick_count = '0;
            end
            else begin
                tick_count++;
                if (tick_count >= response_wait) begin
                    phase = next;
                    tick_count = '0;
                end
            end
        endfunction

        function void accept_command(logic c, logic lvl);
            report_t    r;
            logic [7:0] b0, b1, b2, b3, b4, sum;
            logic [12:0] mag;
            logic       bit_value;
            r = '0;
            if (c ? (phase == PH_IDLE) : (phase != PH_IDLE))
                live_items++;
            if (c) begin
                if (phase == PH_IDLE) begin
                    phase = PH_LOW;
                    tick_count = '0;
                    bit_count = '0;
                    frame = '0;
                end
            end
            else begin
                case (phase)
                    PH_LOW:
                    begin
                        tick_count++;
                        if (tick_count >= start_low) begin
                            phase = PH_HIGH;
                            tick_count = '0;
                        end
                    end
                    PH_HIGH:
                    begin
                        tick_count++;
                        if (tick_count >= release_high) begin
                            phase = PH_RESP_LOW;
                            tick_count = '0;
                        end
                    end
                    PH_RESP_LOW:  wait_for_level(lvl, 1'b0, PH_RESP_HIGH);
                    PH_RESP_HIGH: wait_for_level(lvl, 1'b1, PH_DATA_LOW);
                    PH_DATA_LOW:  wait_for_level(lvl, 1'b0, PH_BIT_RISE);
                    PH_BIT_RISE:
                    begin
                        if (lvl) begin
                            phase = PH_BIT_HIGH;
                            tick_count = 16'd1;
                        end
                        else
                            wait_for_level(lvl, 1'b1, PH_BIT_HIGH);
                    end
                    PH_BIT_HIGH:
                    begin
                        if (lvl) begin
                            tick_count++;
                            if (tick_count > bit_timeout) begin
                                r.done = 1'b1;
                                r.status = STATUS_TIMEOUT;
                                phase = PH_IDLE;
                                tick_count = '0;
                                reads_timeout++;
                            end
                        end
                        else begin
                            bit_value = tick_count > one_threshold;
                            frame = {frame[38:0], bit_value};
                            bit_count++;
                            tick_count = '0;
                            if (bit_count >= FRAME_BIT_COUNT) begin
                                {b0, b1, b2, b3, b4} = frame;
                                sum = b0 + b1 + b2 + b3;
                                r.done = 1'b1;
                                phase = PH_IDLE;
                                if (sum != b4) begin
                                    r.status = STATUS_CHECKSUM;
                                    reads_bad_sum++;
                                end
                                else begin
                                    r.humidity = 13'({b0, b1} / 16'd10);
                                    mag = 13'({b2[6:0], b3} / 15'd10);
                                    r.temperature = b2[7] ? (13'd0 - mag) : mag;
                                    reads_ok++;
                                end
                            end
                            else
                                phase = PH_BIT_RISE;
                        end
                    end
                    default: ;
                endcase
            end
            r.drive_enable = (phase == PH_LOW) || (phase == PH_HIGH);
            r.drive_level = phase == PH_HIGH;
            r.busy = phase != PH_IDLE;
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d, %s: expected 0x%h, got 0x%h", checked, name, want, got);
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            checked++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no transfer waiting for it", checked);
                return;
            end
            want = expected_reports.pop_front();
            check_field("drive_enable", want.drive_enable, got.drive_enable);
            check_field("drive_level", want.drive_level, got.drive_level);
            check_field("busy_res", want.busy, got.busy);
            check_field("done_res", want.done, got.done);
            check_field("status", want.status, got.status);
            check_field("humidity_pct", want.humidity, got.humidity);
            check_field("temperature_c", want.temperature, got.temperature);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic        line_level = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        drive_enable;
    logic        drive_level;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [12:0] humidity_pct;
    logic signed [12:0] temperature_c;

    report_t        seen_report;
    read_scoreboard sb = new();
    int             cycle_no = 0;
    int             results_seen = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    int             transfers_sent = 0;
    int             config_writes = 0;

    assign seen_report = {drive_enable, drive_level, busy_res, done_res, status,
                          humidity_pct, temperature_c};

    single_wire_humidity_sensor_reader_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .line_level   (line_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_enable (drive_enable),
        .drive_level  (drive_level),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .humidity_pct (humidity_pct),
        .temperature_c(temperature_c)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    function bit calm_stretch();
        return cycle_no >= 300 && cycle_no < 700;
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm_stretch() || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_report(seen_report);
            results_seen <= results_seen + 1;
        end
    end

    task automatic send_item(input logic c, input logic lvl);
        int gap;
        if (!calm_stretch() && $urandom_range(0, 99) < 5) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        line_level <= lvl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.accept_command(c, lvl);
        transfers_sent++;
    endtask

    task automatic send_level(input logic lvl, input int count);
        for (int i = 0; i < count; i++) begin
            if (sb.reader_busy() && $urandom_range(0, 99) < 2)
                send_item(1'b1, 1'($urandom_range(0, 1)));
            send_item(1'b0, lvl);
        end
    endtask

    task automatic send_noise(input int count);
        logic lvl;
        lvl = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                lvl = ~lvl;
            send_item(1'($urandom_range(0, 7) == 0), lvl);
        end
    endtask

    task automatic finish_read();
        while (sb.reader_busy()) send_item(1'b0, 1'b0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
        config_writes++;
    endtask

    task automatic load_config(input logic [15:0] low_ticks, input logic [15:0] high_ticks,
                               input logic [15:0] wait_ticks, input logic [15:0] pulse_limit,
                               input logic [15:0] one_limit, input bit poke_unused);
        finish_read();
        drain_results();
        if (poke_unused)
            write_reg(CFG_NO_SUCH_REG, 16'hFFFF);
        write_reg(CFG_START_LOW, low_ticks);
        write_reg(CFG_RELEASE_HIGH, high_ticks);
        write_reg(CFG_RESPONSE, wait_ticks);
        write_reg(CFG_BIT_TIMEOUT, pulse_limit);
        write_reg(CFG_THRESHOLD, one_limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_read(input logic [15:0] hum_raw, input logic [15:0] temp_raw,
                            input flaw_t flaw, input bit pause_mid);
        logic [39:0] word;
        logic [7:0]  sum;
        int          wait_max, lead, flaw_bit, pulse, thr, limit, low_len;
        sum = hum_raw[15:8] + hum_raw[7:0] + temp_raw[15:8] + temp_raw[7:0];
        if (flaw == FLAW_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        word = {hum_raw, temp_raw, sum};
        wait_max = (sb.response_wait == 0) ? 1 : sb.response_wait;
        thr = sb.one_threshold;
        limit = sb.bit_timeout;
        flaw_bit = $urandom_range(0, 39);
        lead = ((sb.start_low == 0) ? 1 : sb.start_low) +
               ((sb.release_high == 0) ? 1 : sb.release_high);

        send_item(1'b1, 1'($urandom_range(0, 1)));
        for (int i = 0; i < lead; i++)
            send_item(1'b0, 1'($urandom_range(0, 1)));
        send_level(1'b1, $urandom_range(0, 2));
        if (flaw == FLAW_SLOW_RESPONSE)
            send_level(1'b0, wait_max + $urandom_range(1, 3));
        else
            send_level(1'b0, $urandom_range(1, (wait_max > 5) ? 5 : wait_max));
        send_level(1'b1, $urandom_range(1, (wait_max > 5) ? 5 : wait_max));

        for (int i = 39; i >= 0; i--) begin
            if (!sb.reader_busy())
                break;
            if (flaw == FLAW_CUT_SHORT && i == flaw_bit) begin
                send_noise($urandom_range(5, 40));
                break;
            end
            if (pause_mid && i == 20)
                drain_results();
            if (flaw == FLAW_SLOW_RISE && i == flaw_bit)
                low_len = wait_max + $urandom_range(1, 3);
            else
                low_len = $urandom_range(1, (wait_max > 3) ? 3 : wait_max);
            send_level(1'b0, low_len);
            if (flaw == FLAW_LONG_PULSE && i == flaw_bit)
                pulse = limit + 1 + $urandom_range(0, 2);
            else if (word[i])
                pulse = ($urandom_range(0, 2) == 0 || limit <= thr) ?
                        thr + 1 : $urandom_range(thr + 1, limit);
            else if (thr == 0)
                pulse = 1;
            else if ($urandom_range(0, 3) == 0)
                pulse = thr;
            else
                pulse = $urandom_range(1, (thr > 30) ? 30 : thr);
            send_level(1'b1, pulse);
        end
        send_level(1'b0, 1);
        finish_read();
    endtask

    initial begin
        #8_000_000;
        $display("Run did not finish in time; %0d results still expected.", sb.pending());
        $display("single_wire_humidity_sensor_reader_top: mismatch");
        $finish;
    end

    initial begin
        int    guard;
        int    read_no;
        flaw_t flaw;
        int    thr;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);

        load_config(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0);
        run_read(16'h0000, 16'h0000, FLAW_NONE, 1'b0);
        run_read(16'h1234, 16'h8000, FLAW_NONE, 1'b0);

        load_config(16'h0000, 16'hA500, 16'h5A00, 16'hFF00, 16'h0100, 1'b1);
        run_read(16'h3C5A, 16'h00F0, FLAW_NONE, 1'b0);

        load_config(16'd2, 16'd1, 16'd3, 16'd4, 16'd1, 1'b0);
        run_read(16'hFFFF, 16'hFFFF, FLAW_NONE, 1'b1);

        read_no = 1;
        while (transfers_sent < TOTAL_ITEMS) begin
            thr = $urandom_range(1, 2);
            load_config(($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                                    : 16'($urandom_range(1, 4)),
                        {8'($urandom), 8'($urandom_range(1, 4))},
                        {8'($urandom), 8'($urandom_range(2, 4))},
                        {8'($urandom), ($urandom_range(0, 9) == 0) ? 8'(thr)
                                       : 8'(thr + $urandom_range(1, 3))},
                        {8'($urandom), 8'(thr)},
                        1'b0);
            if ($urandom_range(0, 5) == 0) begin
                send_noise($urandom_range(10, 40));
                finish_read();
            end
            else begin
                flaw = flaw_t'(read_no % 6);
                read_no++;
                run_read(16'($urandom), 16'($urandom), flaw, 1'b0);
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
            sb.mismatches += sb.pending();
        end

        $display("Sent %0d input transfers (%0d acted on), checked %0d results, %0d register writes.",
                 transfers_sent, sb.live_items, sb.checked, config_writes);
        $display("Reads ended: %0d good, %0d pulse timeouts, %0d checksum errors.",
                 sb.reads_ok, sb.reads_timeout, sb.reads_bad_sum);
        if (sb.mismatches == 0)
            $display("single_wire_humidity_sensor_reader_top: match");
        else
            $display("single_wire_humidity_sensor_reader_top: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/swhsr_pkg.sv
hdl/single_wire_humidity_sensor_reader_top.sv
hdl/swhsr_checker.sv
verif/tb.sv
